// File: sv/trq_pkg.sv
// Shared constants, types and state encodings for the timestamp request queue.
package trq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam int ID_W = 8;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 5;
   localparam int ENTRY_W = ID_W + STAMP_W;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_INSERT = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;
      logic insert;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// File: sv/trq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module trq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/trq_ctrl.sv
// Sequencing state machine for one queue operation.
module trq_ctrl import trq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [REQ_USER_W-1:0] req_func,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (req_func[0] == FUNC_INSERT) ? ST_INSERT : ST_SCAN;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A taken request must be followed by a busy state in which req_tready is low.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted on two consecutive cycles");

endmodule

// File: sv/trq_dpath.sv
// Slot store, occupancy flags, match and head search, and result register.
module trq_dpath import trq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   // Latched request.
   logic               func_ff;
   logic [ID_W-1:0]    id_ff;
   logic [STAMP_W-1:0] stamp_ff;

   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ok_ff, ok_in;

   logic [IDX_W-1:0] scan_idx_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_vld_ff;

   logic               best_found_ff, best_found_in;
   logic [ID_W-1:0]    best_id_ff, best_id_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_ok_ff;
   logic               rsp_head_valid_ff;
   logic [ID_W-1:0]    rsp_head_id_ff;
   logic [STAMP_W-1:0] rsp_head_stamp_ff;

   logic               has_free;
   logic [IDX_W-1:0]   free_idx;
   logic [ENTRY_W-1:0] rd_data;
   logic [ID_W-1:0]    rd_id;
   logic [STAMP_W-1:0] rd_stamp;
   logic               slot_used;
   logic               match;
   logic               take_out;
   logic               better;

   // Lowest free slot.
   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   trq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_slots (
      .clock  (clock),
      .wr_en  (cmd.insert && has_free),
      .wr_addr(free_idx),
      .wr_data({id_ff, stamp_ff}),
      .rd_en  (cmd.scan),
      .rd_addr(scan_idx_ff),
      .rd_data(rd_data)
   );

   assign rd_id = rd_data[ENTRY_W-1:STAMP_W];
   assign rd_stamp = rd_data[STAMP_W-1:0];
   assign slot_used = cmp_vld_ff && valid_ff[cmp_idx_ff];
   assign match = slot_used && (rd_id == id_ff) && (rd_stamp == stamp_ff);
   // Only the first matching slot of a remove is dropped.
   assign take_out = (func_ff == FUNC_REMOVE) && match && !ok_ff;
   assign better = !best_found_ff || (rd_stamp < best_stamp_ff) ||
                   ((rd_stamp == best_stamp_ff) && (rd_id < best_id_ff));

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      ok_in = ok_ff;
      best_found_in = best_found_ff;
      best_id_in = best_id_ff;
      best_stamp_in = best_stamp_ff;
      if (cmd.load) begin
         ok_in = 1'b0;
         best_found_in = 1'b0;
         best_id_in = '0;
         best_stamp_in = '0;
      end
      if (cmd.insert && has_free) begin
         valid_in[free_idx] = 1'b1;
         count_in = count_ff + CNT_W'(1);
         ok_in = 1'b1;
      end
      if (take_out) begin
         valid_in[cmp_idx_ff] = 1'b0;
         count_in = count_ff - CNT_W'(1);
         ok_in = 1'b1;
      end else if (slot_used && better) begin
         best_found_in = 1'b1;
         best_id_in = rd_id;
         best_stamp_in = rd_stamp;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         cmp_vld_ff <= cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser[0];
         id_ff <= req_tdata[ID_W-1:0];
         stamp_ff <= req_tdata[ENTRY_W-1:ID_W];
         scan_idx_ff <= '0;
      end else if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
      cmp_idx_ff <= scan_idx_ff;
      ok_ff <= ok_in;
      best_found_ff <= best_found_in;
      best_id_ff <= best_id_in;
      best_stamp_ff <= best_stamp_in;
      if (cmd.finish) begin
         rsp_count_ff <= COUNT_W'(count_ff);
         rsp_ok_ff <= ok_ff;
         rsp_head_valid_ff <= best_found_ff;
         rsp_head_id_ff <= best_id_ff;
         rsp_head_stamp_ff <= best_stamp_ff;
      end
   end

   assign status.scan_last = (scan_idx_ff == IDX_W'(CAPACITY - 1));
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {(RSP_DATA_W - COUNT_W - ENTRY_W)'(0), rsp_head_stamp_ff,
                       rsp_head_id_ff, rsp_count_ff};
   assign rsp_tuser = {rsp_head_valid_ff, rsp_ok_ff};

   // The entry count always agrees with the occupancy flags.
   assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("entry count out of step with occupancy flags");

   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result register overwritten while still pending");

   // A reported head exists exactly when the queue holds something.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_head_valid_ff == (rsp_count_ff != '0)))
      else $error("head flag disagrees with entry count");

endmodule

// File: sv/timestamp_request_queue_core.sv
// Top level of the timestamp request queue: controller plus slot datapath.
//
// Channel   Dir  Handshake              Contents
// req_      in   req_tvalid/req_tready  tuser: func; tdata: proc_id, stamp
// rsp_      out  rsp_tvalid/rsp_tready  tuser: op_ok, head_valid;
//                                       tdata: entry_count, head_id, head_stamp
//
// One transaction is processed at a time. An operation runs from the accepting
// cycle through a write of the new slot (insert only), then a sweep that reads
// the slot RAM one entry per cycle over all CAPACITY slots, then a drain step
// for the last compare and a finish step that loads the result register. The
// single read port of the slot RAM sets the length of the sweep.
// Reset is synchronous and active high; it empties the queue at once by
// clearing the per-slot occupancy flags, so no clearing pass is needed.
// A finished result sits in an output register; the block waits in its
// final state when that register is still full and rsp_tready is low.
module timestamp_request_queue_core import trq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] proc_id, [39:8] stamp
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [4:0] entry_count, [12:5] head_id, [44:13] head_stamp, [47:45] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] op_ok, [1] head_valid
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   // The controller decides the order of steps: accept, optional slot write,
   // sweep, drain of the last compare, and hand-off to the output register.
   trq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_func  (req_tuser),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the slots, finds the lowest free slot for an insert,
   // removes the first match during the sweep and tracks the earliest request
   // (least stamp, ties to the least id) among the slots that remain.
   trq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
